/* src/ftsa_pkg.sv */
// Shared types and codes for the flow table sequence checker.
package ftsa_pkg;

  localparam int KEY_W   = 48;
  localparam int CHUNK_W = 32;

  // Result codes reported with every word on the result channel
  typedef enum logic [1:0] {
    OUT_ACK   = 2'd0,
    OUT_ORDER = 2'd1,
    OUT_FREED = 2'd2,
    OUT_FULL  = 2'd3
  } outcome_t;

  // Lookup word that walks the cell chain; slot numbers travel beside it
  typedef struct packed {
    logic               vld;
    logic [KEY_W-1:0]   key;
    logic               empty;
    logic [CHUNK_W-1:0] chunk;
    logic               hit;
    logic               free;
    logic [CHUNK_W-1:0] hit_last;
  } probe_t;

  // Entry write broadcast from the controller to every cell
  typedef struct packed {
    logic               en;
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [CHUNK_W-1:0] last;
  } upd_t;

endpackage

/* src/ftsa_dgram_if.sv */
// Datagram descriptor channel.
interface ftsa_dgram_if;
  logic               valid;
  logic               ready;
  logic [47:0]        sender_key;
  logic               is_empty;
  logic signed [31:0] chunk_number;

  modport source (output valid, sender_key, is_empty, chunk_number, input ready);
  modport sink   (input valid, sender_key, is_empty, chunk_number, output ready);
endinterface

/* src/ftsa_result_if.sv */
// Result channel.
interface ftsa_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         outcome;
  logic [2:0]         slot_index;
  logic signed [31:0] ack_chunk;

  modport source (output valid, outcome, slot_index, ack_chunk, input ready);
  modport sink   (input valid, outcome, slot_index, ack_chunk, output ready);
endinterface

/* src/ftsa_cell.sv */
// One table entry: holds its connection and checks the passing lookup word.
module ftsa_cell #(
  parameter int SLOT_W = 3,
  parameter int SLOT   = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                stall,
  input  ftsa_pkg::probe_t    probe_in,
  input  logic [SLOT_W-1:0]   hit_slot_in,
  input  logic [SLOT_W-1:0]   free_slot_in,
  input  ftsa_pkg::upd_t      upd,
  input  logic [SLOT_W-1:0]   upd_slot,
  output ftsa_pkg::probe_t    probe_out,
  output logic [SLOT_W-1:0]   hit_slot_out,
  output logic [SLOT_W-1:0]   free_slot_out
);
  import ftsa_pkg::*;

  localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(SLOT);

  logic               valid;
  logic [KEY_W-1:0]   key;
  logic [CHUNK_W-1:0] last;

  probe_t            probe_next;
  logic [SLOT_W-1:0] hit_slot_next;
  logic [SLOT_W-1:0] free_slot_next;

  // Claim the word: first matching entry wins, latest free entry overrides
  always_comb begin
    probe_next     = probe_in;
    hit_slot_next  = hit_slot_in;
    free_slot_next = free_slot_in;
    if (probe_in.vld && !probe_in.hit) begin
      if (!valid) begin
        probe_next.free = 1'b1;
        free_slot_next  = MY_SLOT;
      end else if (key == probe_in.key) begin
        probe_next.hit      = 1'b1;
        probe_next.hit_last = last;
        hit_slot_next       = MY_SLOT;
      end
    end
  end

  // Advance the lookup word to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out.vld <= 1'b0;
    end else if (!stall) begin
      probe_out.vld <= probe_next.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      probe_out.key      <= probe_next.key;
      probe_out.empty    <= probe_next.empty;
      probe_out.chunk    <= probe_next.chunk;
      probe_out.hit      <= probe_next.hit;
      probe_out.free     <= probe_next.free;
      probe_out.hit_last <= probe_next.hit_last;
      hit_slot_out       <= hit_slot_next;
      free_slot_out      <= free_slot_next;
    end
  end

  // Entry storage, written by the controller broadcast
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (upd.en && upd_slot == MY_SLOT) begin
      valid <= upd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.en && upd_slot == MY_SLOT) begin
      key  <= upd.key;
      last <= upd.last;
    end
  end

endmodule

/* src/flow_table_sequence_acker_unit.sv */
// Top level: connection table as a chain of entry cells plus the decision logic.
//
// Usage: datagram descriptors enter on the dgram channel (sender key, empty
// flag, chunk number); exactly one word leaves on the result channel per
// descriptor, in order (outcome, slot, acknowledged chunk). Both channels
// move a word at a clock edge where valid and ready are high.
// A descriptor walks the chain of TABLE_ENTRIES cells, one cell per cycle,
// collecting the matching entry and the highest free entry. When it leaves
// the last cell the controller picks the outcome, writes the chosen entry
// if the outcome changes it, and loads the output register in the same cycle.
// The descriptor is registered in each cell in turn, then in the output
// register. A new descriptor is taken only after the last one has left
// the cell chain (one item in the chain at a time).
// Reset (synchronous, rst high) frees every entry and empties the chain and
// the output register at once; no clearing pass is needed.
// If the receiver stalls while a result waits, the next descriptor can still
// be taken and walk the chain; it holds at the chain end until the waiting
// result is taken.
module flow_table_sequence_acker_unit #(
  parameter int TABLE_ENTRIES = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  ftsa_dgram_if.sink           dgram,
  ftsa_result_if.source        result
);
  import ftsa_pkg::*;

  localparam int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  probe_t            head;
  probe_t            chain      [TABLE_ENTRIES];
  logic [SLOT_W-1:0] chain_hit  [TABLE_ENTRIES];
  logic [SLOT_W-1:0] chain_free [TABLE_ENTRIES];

  probe_t            tail;
  logic [SLOT_W-1:0] tail_hit;
  logic [SLOT_W-1:0] tail_free;

  logic busy;
  logic stall;
  logic fire;
  logic accept;

  upd_t              upd;
  logic [SLOT_W-1:0] upd_slot;

  outcome_t           res_outcome;
  logic [SLOT_W+2:0]  res_slot_ext;
  logic [CHUNK_W-1:0] res_ack;
  logic [SLOT_W-1:0]  sel_slot;
  logic [CHUNK_W-1:0] sel_base;
  logic               sel_new;

  logic               out_valid;
  outcome_t           out_outcome;
  logic [2:0]         out_slot;
  logic [CHUNK_W-1:0] out_ack;

  // One descriptor in the chain at a time
  assign dgram.ready = !busy;
  assign accept      = dgram.valid && !busy;

  // Inject the accepted descriptor into the first cell
  always_comb begin
    head.vld      = accept;
    head.key      = dgram.sender_key;
    head.empty    = dgram.is_empty;
    head.chunk    = dgram.chunk_number;
    head.hit      = 1'b0;
    head.free     = 1'b0;
    head.hit_last = '0;
  end

  // Cell chain
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    probe_t            p_in;
    logic [SLOT_W-1:0] h_in;
    logic [SLOT_W-1:0] f_in;

    if (i == 0) begin : g_first
      assign p_in = head;
      assign h_in = '0;
      assign f_in = '0;
    end else begin : g_rest
      assign p_in = chain[i-1];
      assign h_in = chain_hit[i-1];
      assign f_in = chain_free[i-1];
    end

    ftsa_cell #(
      .SLOT_W (SLOT_W),
      .SLOT   (i)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .stall        (stall),
      .probe_in     (p_in),
      .hit_slot_in  (h_in),
      .free_slot_in (f_in),
      .upd          (upd),
      .upd_slot     (upd_slot),
      .probe_out    (chain[i]),
      .hit_slot_out (chain_hit[i]),
      .free_slot_out(chain_free[i])
    );
  end

  assign tail      = chain[TABLE_ENTRIES-1];
  assign tail_hit  = chain_hit[TABLE_ENTRIES-1];
  assign tail_free = chain_free[TABLE_ENTRIES-1];

  // Hold the chain end while the output register is full and not taken
  assign stall = tail.vld && out_valid && !result.ready;
  assign fire  = tail.vld && !stall;

  // Pick the entry, the outcome and the entry write
  always_comb begin
    sel_slot    = tail_hit;
    sel_base    = tail.hit_last;
    sel_new     = 1'b0;
    if (!tail.hit) begin
      sel_slot = tail_free;
      sel_base = '0;
      sel_new  = 1'b1;
    end

    upd.en      = 1'b0;
    upd.valid   = 1'b1;
    upd.key     = tail.key;
    upd.last    = '0;
    upd_slot    = sel_slot;
    res_outcome = OUT_FULL;
    res_slot_ext = '0;
    res_ack     = '0;

    priority if (!tail.hit && !tail.free) begin
      res_outcome = OUT_FULL;
    end else if (tail.empty) begin
      res_outcome  = OUT_FREED;
      res_slot_ext = (SLOT_W+3)'(sel_slot);
      upd.en       = fire;
      upd.valid    = 1'b0;
      upd.key      = '0;
    end else if (tail.chunk == CHUNK_W'(sel_base + 32'd1)) begin
      res_outcome  = OUT_ACK;
      res_slot_ext = (SLOT_W+3)'(sel_slot);
      res_ack      = tail.chunk;
      upd.en       = fire;
      upd.last     = tail.chunk;
    end else begin
      res_outcome  = OUT_ORDER;
      res_slot_ext = (SLOT_W+3)'(sel_slot);
      upd.en       = fire && sel_new;
    end
  end

  // Busy from accept until the result is loaded
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (fire) begin
      busy <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_outcome <= res_outcome;
      out_slot    <= res_slot_ext[2:0];
      out_ack     <= res_ack;
    end
  end

  assign result.valid      = out_valid;
  assign result.outcome    = out_outcome;
  assign result.slot_index = out_slot;
  assign result.ack_chunk  = out_ack;

endmodule

/* test/flow_table_sequence_acker_unit_tb.sv */
// Testbench for the flow table sequence checker: directed table, then random traffic.
`timescale 1ns / 100ps

module flow_table_sequence_acker_unit_tb;
  import ftsa_pkg::*;

  localparam int SLOTS        = 8;
  localparam int PEER_COUNT   = 11;
  localparam int RANDOM_WORDS = 430;
  localparam int LONG_HOLD    = 150;
  localparam int WATCHDOG_MAX = 2000;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic               empty;
    logic [CHUNK_W-1:0] chunk;
  } datagram_t;

  typedef struct packed {
    outcome_t           outcome;
    logic [2:0]         slot;
    logic [CHUNK_W-1:0] ack;
  } verdict_t;

  typedef struct packed {
    datagram_t gram;
    logic      pinned;
    verdict_t  want;
  } script_row_t;

  logic clk;
  logic rst = 1'b1;

  ftsa_dgram_if  dgram_ch ();
  ftsa_result_if result_ch ();

  flow_table_sequence_acker_unit #(
    .TABLE_ENTRIES(SLOTS)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .dgram (dgram_ch),
    .result(result_ch)
  );

  // Shadow connection table
  logic               conn_valid [SLOTS];
  logic [KEY_W-1:0]   conn_key   [SLOTS];
  logic [CHUNK_W-1:0] conn_last  [SLOTS];

  verdict_t           verdicts_due[$];
  script_row_t        script[$];
  logic [KEY_W-1:0]   peer_pool[PEER_COUNT];

  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  bit  hold_request   = 1'b0;
  bit  hold_served    = 1'b0;
  int  fault_count    = 0;
  int  quiet_cycles   = 0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int find_slot(logic [KEY_W-1:0] key);
    for (int s = 0; s < SLOTS; s++) begin
      if (conn_valid[s] && conn_key[s] == key) return s;
    end
    return -1;
  endfunction

  // Apply one descriptor to the shadow table and return the expected result
  function automatic verdict_t track_sequence(datagram_t d);
    verdict_t v;
    int       slot;
    int       free_slot;
    v.outcome = OUT_FULL;
    v.slot    = 3'd0;
    v.ack     = '0;
    free_slot = -1;
    for (int s = 0; s < SLOTS; s++) begin
      if (!conn_valid[s]) free_slot = s;
    end
    slot = find_slot(d.key);
    if (slot < 0) begin
      if (free_slot < 0) return v;
      slot             = free_slot;
      conn_valid[slot] = 1'b1;
      conn_key[slot]   = d.key;
      conn_last[slot]  = '0;
    end
    v.slot = slot[2:0];
    if (d.empty) begin
      conn_valid[slot] = 1'b0;
      conn_key[slot]   = '0;
      conn_last[slot]  = '0;
      v.outcome        = OUT_FREED;
    end else if (d.chunk == conn_last[slot] + 32'd1) begin
      conn_last[slot] = d.chunk;
      v.outcome       = OUT_ACK;
      v.ack           = d.chunk;
    end else begin
      v.outcome = OUT_ORDER;
    end
    return v;
  endfunction

  function automatic logic [CHUNK_W-1:0] next_chunk_for(logic [KEY_W-1:0] key);
    int slot;
    slot = find_slot(key);
    return (slot < 0) ? 32'd1 : conn_last[slot] + 32'd1;
  endfunction

  function automatic logic [KEY_W-1:0] random_key();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[KEY_W-1:0];
  endfunction

  // Mostly in-order traffic from a small peer set, with closes, stray chunks and strangers
  function automatic datagram_t make_datagram();
    datagram_t d;
    int        pick;
    int        s;
    pick    = $urandom_range(0, 99);
    d.key   = peer_pool[$urandom_range(0, PEER_COUNT - 1)];
    d.empty = 1'b0;
    d.chunk = next_chunk_for(d.key);
    if (pick < 8) begin
      d.empty = 1'b1;
      d.chunk = $urandom;
    end else if (pick < 12) begin
      s       = $urandom_range(0, SLOTS - 1);
      d.empty = 1'b1;
      d.chunk = $urandom;
      if (conn_valid[s]) d.key = conn_key[s];
    end else if (pick < 22) begin
      d.chunk = $urandom;
    end else if (pick < 27) begin
      d.key   = random_key();
      d.empty = 1'($urandom_range(0, 1));
      d.chunk = $urandom;
    end
    return d;
  endfunction

  task automatic add_row(logic [KEY_W-1:0] key, logic empty, logic [CHUNK_W-1:0] chunk,
                         logic pinned, outcome_t outcome, logic [2:0] slot,
                         logic [CHUNK_W-1:0] ack);
    script_row_t r;
    r.gram.key     = key;
    r.gram.empty   = empty;
    r.gram.chunk   = chunk;
    r.pinned       = pinned;
    r.want.outcome = outcome;
    r.want.slot    = slot;
    r.want.ack     = ack;
    script.push_back(r);
  endtask

  // Offer one word, with a random gap first; entered and left at a rising edge
  task automatic offer_datagram(datagram_t d, logic pinned, verdict_t want);
    int       gap;
    verdict_t predicted;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      dgram_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    dgram_ch.valid        <= 1'b1;
    dgram_ch.sender_key   <= d.key;
    dgram_ch.is_empty     <= d.empty;
    dgram_ch.chunk_number <= d.chunk;
    @(negedge clk);
    while (!dgram_ch.ready) @(negedge clk);
    predicted = track_sequence(d);
    verdicts_due.push_back(pinned ? want : predicted);
    @(posedge clk);
  endtask

  // Stimulus
  initial begin : stimulus
    localparam logic [KEY_W-1:0] KEY_A   = 48'h0A00_0001_1F90;
    localparam logic [KEY_W-1:0] KEY_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [KEY_W-1:0] KEY_NEW = 48'hC0A8_0102_0035;
    verdict_t none;
    none                  = '0;
    dgram_ch.valid        = 1'b0;
    dgram_ch.sender_key   = '0;
    dgram_ch.is_empty     = 1'b0;
    dgram_ch.chunk_number = '0;
    for (int s = 0; s < SLOTS; s++) begin
      conn_valid[s] = 1'b0;
      conn_key[s]   = '0;
      conn_last[s]  = '0;
    end
    for (int p = 0; p < PEER_COUNT; p++) peer_pool[p] = random_key();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // First connection lands in the highest entry
    add_row(KEY_A,   1'b0, 32'd1,          1'b1, OUT_ACK,   3'd7, 32'd1);
    add_row(KEY_A,   1'b0, 32'd3,          1'b1, OUT_ORDER, 3'd7, 32'd0);
    add_row(KEY_A,   1'b0, 32'd2,          1'b1, OUT_ACK,   3'd7, 32'd2);
    // Chunk extremes against a fresh entry
    add_row(KEY_MAX, 1'b0, 32'h8000_0000,  1'b1, OUT_ORDER, 3'd6, 32'd0);
    add_row(KEY_MAX, 1'b0, 32'h7FFF_FFFF,  1'b1, OUT_ORDER, 3'd6, 32'd0);
    add_row(KEY_MAX, 1'b0, 32'hFFFF_FFFF,  1'b1, OUT_ORDER, 3'd6, 32'd0);
    add_row(KEY_MAX, 1'b0, 32'd1,          1'b1, OUT_ACK,   3'd6, 32'd1);
    // Close from a stranger leaves the table as it was
    add_row(48'd0,   1'b1, 32'd0,          1'b1, OUT_FREED, 3'd5, 32'd0);
    add_row(KEY_A,   1'b1, 32'hDEAD_BEEF,  1'b1, OUT_FREED, 3'd7, 32'd0);
    add_row(KEY_A,   1'b0, 32'd1,          1'b1, OUT_ACK,   3'd7, 32'd1);
    add_row(KEY_A,   1'b0, 32'd0,          1'b1, OUT_ORDER, 3'd7, 32'd0);
    // Fill the rest of the table
    for (int k = 1; k <= 6; k++) begin
      add_row({32'h0A0B_0C00 + 32'(k), 16'h4000 + 16'(k)}, 1'b0, 32'd1, 1'b0, OUT_ACK,
              3'd0, 32'd0);
    end
    // Full table drops data and closes alike
    add_row(KEY_NEW, 1'b0, 32'd1,          1'b1, OUT_FULL,  3'd0, 32'd0);
    add_row(KEY_NEW, 1'b1, 32'd0,          1'b1, OUT_FULL,  3'd0, 32'd0);
    add_row({32'h0A0B_0C03, 16'h4003}, 1'b1, 32'd0, 1'b1, OUT_FREED, 3'd3, 32'd0);
    // Out-of-order first word keeps its entry
    add_row(KEY_NEW, 1'b0, 32'd2,          1'b0, OUT_ACK,   3'd0, 32'd0);
    add_row(KEY_NEW, 1'b0, 32'd1,          1'b0, OUT_ACK,   3'd0, 32'd0);
    add_row(KEY_MAX, 1'b1, 32'd0,          1'b1, OUT_FREED, 3'd6, 32'd0);

    send_idle_pct  = 7;
    recv_stall_pct = 47;
    foreach (script[i]) offer_datagram(script[i].gram, script[i].pinned, script[i].want);

    for (int phase = 0; phase < 3; phase++) begin
      unique case (phase)
        0: begin
          send_idle_pct  = 7;
          recv_stall_pct = 47;
        end
        1: begin
          send_idle_pct  = 47;
          recv_stall_pct = 7;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_request   = 1'b1;
        end
      endcase
      repeat (RANDOM_WORDS) offer_datagram(make_datagram(), 1'b0, none);
    end
    dgram_ch.valid <= 1'b0;

    // Drain, then give stray results time to show up
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (3 * SLOTS) @(posedge clk);
    if (fault_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Result receiver with random stalls and one long hold-off
  initial begin : result_sink
    int held;
    result_ch.ready = 1'b0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (hold_request && !hold_served) begin
        hold_served = 1'b1;
        result_ch.ready <= 1'b0;
        for (held = 0; held < LONG_HOLD; held++) @(posedge clk);
      end else begin
        result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Check each result word against the oldest expectation
  always @(negedge clk) begin
    verdict_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (verdicts_due.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_MAX)
          $display("ERROR: unexpected result: outcome %0d slot %0d ack %h",
                   result_ch.outcome, result_ch.slot_index, result_ch.ack_chunk);
      end else begin
        want = verdicts_due.pop_front();
        if (result_ch.outcome !== want.outcome || result_ch.slot_index !== want.slot ||
            result_ch.ack_chunk !== want.ack) begin
          fault_count++;
          if (fault_count <= REPORT_MAX)
            $display("ERROR: result mismatch: expected outcome %0d slot %0d ack %h, got %0d %0d %h",
                     want.outcome, want.slot, want.ack,
                     result_ch.outcome, result_ch.slot_index, result_ch.ack_chunk);
        end
      end
    end
  end

  // Watchdog: end the run when no word moves for too long
  always @(negedge clk) begin
    if (!rst) begin
      if ((dgram_ch.valid && dgram_ch.ready) || (result_ch.valid && result_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("ERROR: timeout, no word moved in %0d cycles", WATCHDOG_MAX);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

endmodule
